FILE: sv/spu_pkg.sv
// ---------------------------------------------------------------------------
// spu_pkg
// Types and constants shared by the starfield projection unit
// ---------------------------------------------------------------------------
package spu_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEPTH_STEP    = 3'd2;
  localparam logic [2:0] REG_FAR_DEPTH     = 3'd3;
  localparam logic [2:0] REG_PEN_BAND      = 3'd4;

  // reset values of the registers
  localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd320;
  localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd256;
  localparam logic [7:0]  RST_DEPTH_STEP    = 8'd10;
  localparam logic [9:0]  RST_FAR_DEPTH     = 10'd500;
  localparam logic [9:0]  RST_PEN_BAND      = 10'd200;

  // item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [8:0]         star_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [9:0]         load_depth;
  } in_word_t;

  typedef struct packed {
    logic        visible;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [10:0] pen;
  } out_word_t;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [7:0]  depth_step;
    logic [9:0]  far_depth;
    logic [9:0]  pen_band;
  } cfg_t;

  // word handed from front to back
  typedef struct packed {
    logic               adv;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         z;
  } q_item_t;

endpackage

FILE: sv/starfield_projection_unit.sv
// ---------------------------------------------------------------------------
// starfield_projection_unit
// Star table with per-star depth update and perspective projection
// ---------------------------------------------------------------------------
// One word may be started every clock cycle while busy is low. Each word
// gives exactly one result, strobed on out_valid for a single cycle once
// it has passed the table stage, the queue and the sixteen-step divider
// pipeline in the back end. Results cannot be held off. The star table has
// a read and a write port; back-to-back updates of one star are forwarded.
module starfield_projection_unit import spu_pkg::*; #(
  parameter int NUM_STARS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t    cfg_r;
  logic    accept, push, pop_ok, full;
  q_item_t push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
      cfg_r.depth_step    <= RST_DEPTH_STEP;
      cfg_r.far_depth     <= RST_FAR_DEPTH;
      cfg_r.pen_band      <= RST_PEN_BAND;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data;
        REG_DEPTH_STEP:    cfg_r.depth_step    <= cfg_data[7:0];
        REG_FAR_DEPTH:     cfg_r.far_depth     <= cfg_data[9:0];
        REG_PEN_BAND:      cfg_r.pen_band      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign busy   = full;
  assign accept = start && !busy;

  spu_front #(.NUM_STARS(NUM_STARS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_word),
    .cfg       (cfg_r),
    .push      (push),
    .push_item (push_item)
  );

  // back end never stalls, so it pops whenever a word is waiting
  spu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (1'b1),
    .not_empty (pop_ok),
    .full      (full),
    .pop_item  (pop_item)
  );

  spu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pop_ok),
    .in_item   (pop_item),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: sv/spu_front.sv
// ---------------------------------------------------------------------------
// spu_front
// Accepts words, keeps the star table and does the per-star load or depth update
// ---------------------------------------------------------------------------
module spu_front import spu_pkg::*; #(
  parameter int NUM_STARS = 512
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_word_t in_word,
  input  cfg_t     cfg,
  output logic     push,
  output q_item_t  push_item
);

  localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

  logic signed [15:0] mem_x [NUM_STARS];
  logic signed [15:0] mem_y [NUM_STARS];
  logic [9:0]         mem_z [NUM_STARS];

  logic               s1_valid_r;
  in_word_t           s1_word_r;
  logic signed [15:0] rd_x_r, rd_y_r;
  logic [9:0]         rd_z_r;

  logic               fw_valid_r;
  logic [AW-1:0]      fw_addr_r;
  logic signed [15:0] fw_x_r, fw_y_r;
  logic [9:0]         fw_z_r;

  logic [AW-1:0]      rd_addr, s1_addr;
  logic               s1_inrange;
  logic signed [15:0] cur_x, cur_y, new_x, new_y;
  logic [9:0]         cur_z, new_z, far_eff;
  logic signed [10:0] diff;
  logic               wr_en;

  assign rd_addr = AW'(in_word.star_index);
  assign s1_addr = AW'(s1_word_r.star_index);
  assign s1_inrange = (32'(s1_word_r.star_index) < NUM_STARS);

  // stage 0: capture word, read the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
      rd_x_r    <= mem_x[rd_addr];
      rd_y_r    <= mem_y[rd_addr];
      rd_z_r    <= mem_z[rd_addr];
    end
  end

  // forward the write made at the edge our read was taken
  always_comb begin
    if (fw_valid_r && fw_addr_r == s1_addr) begin
      cur_x = fw_x_r;
      cur_y = fw_y_r;
      cur_z = fw_z_r;
    end else begin
      cur_x = rd_x_r;
      cur_y = rd_y_r;
      cur_z = rd_z_r;
    end
  end

  // stage 1: load or advance with respawn
  always_comb begin
    far_eff = (cfg.far_depth == 10'd0) ? 10'd1 : cfg.far_depth;
    diff    = $signed({1'b0, cur_z}) - $signed({3'b000, cfg.depth_step});
    new_x   = cur_x;
    new_y   = cur_y;
    new_z   = diff[9:0];
    if (s1_word_r.mode == MODE_LOAD) begin
      new_x = s1_word_r.coord_x;
      new_y = s1_word_r.coord_y;
      new_z = s1_word_r.load_depth;
    end else if (diff[10] || diff == 11'sd0) begin
      new_x = s1_word_r.coord_x;
      new_y = s1_word_r.coord_y;
      new_z = far_eff;
    end
    wr_en = s1_valid_r && s1_inrange;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[s1_addr] <= new_x;
      mem_y[s1_addr] <= new_y;
      mem_z[s1_addr] <= new_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else begin
      fw_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fw_addr_r <= s1_addr;
    fw_x_r    <= new_x;
    fw_y_r    <= new_y;
    fw_z_r    <= new_z;
  end

  assign push          = s1_valid_r;
  assign push_item.adv = (s1_word_r.mode == MODE_ADVANCE) && s1_inrange;
  assign push_item.x   = new_x;
  assign push_item.y   = new_y;
  assign push_item.z   = new_z;

endmodule

FILE: sv/spu_queue.sv
// ---------------------------------------------------------------------------
// spu_queue
// Two-entry queue between front and back
// ---------------------------------------------------------------------------
module spu_queue import spu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output logic    not_empty,
  output logic    full,
  output q_item_t pop_item
);

  q_item_t    buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop_item  = buf_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && not_empty)) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop && not_empty) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && not_empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/spu_back.sv
// ---------------------------------------------------------------------------
// spu_back
// Pipelined dividers for x/z, y/z and z/band, then clip and pen
// ---------------------------------------------------------------------------
module spu_back import spu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  q_item_t   in_item,
  input  cfg_t      cfg,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int NSTG = 16;

  typedef struct packed {
    logic        adv;
    logic        neg_x;
    logic        neg_y;
    logic [10:0] rem_x;
    logic [15:0] num_x;
    logic [10:0] rem_y;
    logic [15:0] num_y;
    logic [10:0] rem_p;
    logic [15:0] num_p;
    logic [9:0]  div;
  } dstage_t;

  dstage_t    stg_r   [NSTG+1];
  logic       vld_r   [NSTG+1];
  logic [9:0] band_eff;

  // one restoring step: remainder and numerator shift, quotient bit enters at the bottom
  function automatic logic [26:0] div_step(input logic [10:0] rem, input logic [15:0] num,
                                           input logic [9:0] dv);
    logic [10:0] t;
    logic        q;
    t = {rem[9:0], num[15]};
    q = (t >= {1'b0, dv});
    if (q) begin
      t = t - {1'b0, dv};
    end
    return {t, num[14:0], q};
  endfunction

  assign band_eff = (cfg.pen_band == 10'd0) ? 10'd1 : cfg.pen_band;

  // entry stage: magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0].adv   <= in_item.adv;
    stg_r[0].neg_x <= in_item.x[15];
    stg_r[0].neg_y <= in_item.y[15];
    stg_r[0].rem_x <= 11'd0;
    stg_r[0].rem_y <= 11'd0;
    stg_r[0].rem_p <= 11'd0;
    stg_r[0].num_x <= in_item.x[15] ? 16'(-in_item.x) : in_item.x;
    stg_r[0].num_y <= in_item.y[15] ? 16'(-in_item.y) : in_item.y;
    stg_r[0].num_p <= {6'd0, in_item.z};
    stg_r[0].div   <= in_item.z;
  end

  // divider stages, one quotient bit each
  for (genvar i = 0; i < NSTG; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      stg_r[i+1].adv   <= stg_r[i].adv;
      stg_r[i+1].neg_x <= stg_r[i].neg_x;
      stg_r[i+1].neg_y <= stg_r[i].neg_y;
      stg_r[i+1].div   <= stg_r[i].div;
      {stg_r[i+1].rem_x, stg_r[i+1].num_x} <=
        div_step(stg_r[i].rem_x, stg_r[i].num_x, stg_r[i].div);
      {stg_r[i+1].rem_y, stg_r[i+1].num_y} <=
        div_step(stg_r[i].rem_y, stg_r[i].num_y, stg_r[i].div);
      {stg_r[i+1].rem_p, stg_r[i+1].num_p} <=
        div_step(stg_r[i].rem_p, stg_r[i].num_p, band_eff);
    end
  end

  // sign fix, center offset, clip
  logic signed [16:0] qx, qy;
  logic signed [17:0] px, py;
  logic               vis;
  out_word_t          res;

  always_comb begin
    qx  = stg_r[NSTG].neg_x ? -$signed({1'b0, stg_r[NSTG].num_x})
                            : $signed({1'b0, stg_r[NSTG].num_x});
    qy  = stg_r[NSTG].neg_y ? -$signed({1'b0, stg_r[NSTG].num_y})
                            : $signed({1'b0, stg_r[NSTG].num_y});
    px  = $signed({6'd0, cfg.screen_width[12:1]}) + 18'(qx);
    py  = $signed({6'd0, cfg.screen_height[12:1]}) + 18'(qy);
    vis = stg_r[NSTG].adv &&
          !px[17] && (px[16:0] < {4'd0, cfg.screen_width}) &&
          !py[17] && (py[16:0] < {4'd0, cfg.screen_height});
    res = '0;
    if (vis) begin
      res.visible = 1'b1;
      res.pixel_x = px[11:0];
      res.pixel_y = py[11:0];
      res.pen     = stg_r[NSTG].num_p[10:0] + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    out_word <= res;
  end

endmodule

FILE: bench/tb_starfield_projection_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_starfield_projection_unit
// Self-checking bench for the starfield projection unit
// ---------------------------------------------------------------------------
// A short table of directed words runs first. Rows with an obvious answer
// carry a hand-typed expectation. Random phases follow under several register
// settings, the extremes among them. Every result is matched in order against its
// typed expectation or a star table model kept in this bench. Sender gaps are
// random; the result side cannot stall.
module tb_starfield_projection_unit;
  import spu_pkg::*;

  localparam int NSTARS     = 512;
  localparam int LATENCY    = 19;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_WORDS = 352;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  starfield_projection_unit #(.NUM_STARS(NSTARS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // star table and register copies held by the bench
  logic signed [15:0] star_x [NSTARS];
  logic signed [15:0] star_y [NSTARS];
  logic [9:0]         star_z [NSTARS];
  bit                 star_loaded [NSTARS];
  logic [12:0] sh_width, sh_height;
  logic [7:0]  sh_step;
  logic [9:0]  sh_far, sh_band;

  out_word_t pending_pixels [$];
  int errors;
  int cycles;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } row_t;

  function automatic in_word_t mk(logic m, int idx, int x, int y, int d);
    in_word_t w;
    w.mode = m; w.star_index = idx[8:0]; w.coord_x = x[15:0];
    w.coord_y = y[15:0]; w.load_depth = d[9:0];
    return w;
  endfunction

  function automatic out_word_t mk_res(bit v, int px, int py, int pen);
    out_word_t r;
    r.visible = v; r.pixel_x = px[11:0]; r.pixel_y = py[11:0]; r.pen = pen[10:0];
    return r;
  endfunction

  // load one star, or move one star and project it
  function automatic out_word_t project_star(in_word_t w);
    out_word_t r;
    int idx, z, far, band, sx, sy, px, py;
    r = '0;
    idx = int'(w.star_index);
    if (idx >= NSTARS) return r;
    if (w.mode == MODE_LOAD) begin
      star_x[idx] = w.coord_x; star_y[idx] = w.coord_y;
      star_z[idx] = w.load_depth; star_loaded[idx] = 1'b1;
      return r;
    end
    far  = (sh_far == 0) ? 1 : int'(sh_far);
    band = (sh_band == 0) ? 1 : int'(sh_band);
    z = int'(star_z[idx]) - int'(sh_step);
    // star passed the viewer: respawn far away at the given spot
    if (z <= 0) begin
      star_x[idx] = w.coord_x; star_y[idx] = w.coord_y;
      z = far;
    end
    star_z[idx] = z[9:0];
    sx = int'(star_x[idx]);
    sy = int'(star_y[idx]);
    px = int'(sh_width >> 1) + sx / z;
    py = int'(sh_height >> 1) + sy / z;
    if (px >= 0 && px < int'(sh_width) && py >= 0 && py < int'(sh_height)) begin
      r.visible = 1'b1; r.pixel_x = px[11:0]; r.pixel_y = py[11:0];
      r.pen = 11'((z / band) + 1);
    end
    return r;
  endfunction

  // random sender gap, mostly short
  task automatic sender_gap();
    int g, k;
    k = $urandom_range(0, 9);
    g = (k < 6) ? 0 : (k < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // present one word and hold it until taken
  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    out_word_t p;
    sender_gap();
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    p = project_star(w);
    pending_pixels.push_back(typed ? res : p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  sh_width  = val[12:0];
      REG_SCREEN_HEIGHT: sh_height = val[12:0];
      REG_DEPTH_STEP:    sh_step   = val[7:0];
      REG_FAR_DEPTH:     sh_far    = val[9:0];
      REG_PEN_BAND:      sh_band   = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int wd, int ht, int st, int fr, int bd);
    write_reg(REG_SCREEN_WIDTH, wd);
    write_reg(REG_SCREEN_HEIGHT, ht);
    write_reg(REG_DEPTH_STEP, st);
    write_reg(REG_FAR_DEPTH, fr);
    write_reg(REG_PEN_BAND, bd);
  endtask

  task automatic random_phase(int n);
    in_word_t w;
    int idx, k;
    for (int i = 0; i < n; i++) begin
      w = '0;
      k = $urandom_range(0, 9);
      if (k < 3) begin
        w.mode = MODE_LOAD;
        w.star_index = 9'($urandom_range(0, NSTARS - 1));
        w.load_depth = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 15))
                                                   : 10'($urandom_range(0, 1023));
      end else begin
        w.mode = MODE_ADVANCE;
        do idx = $urandom_range(0, NSTARS - 1); while (!star_loaded[idx]);
        w.star_index = 9'(idx);
        w.load_depth = 10'($urandom);
      end
      // coordinates: mostly the usual span, sometimes any 16-bit value
      if ($urandom_range(0, 3) == 0) begin
        w.coord_x = 16'($urandom); w.coord_y = 16'($urandom);
      end else begin
        w.coord_x = 16'($urandom_range(0, 39999) - 15000);
        w.coord_y = 16'($urandom_range(0, 39999) - 15000);
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  // result checker and run limit
  always @(posedge clk) begin
    out_word_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected word %h", out_word);
      end else begin
        e = pending_pixels.pop_front();
        if (out_word.visible !== e.visible || out_word.pixel_x !== e.pixel_x ||
            out_word.pixel_y !== e.pixel_y || out_word.pen !== e.pen) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: exp vis %0d x %0d y %0d pen %0d, got vis %0d x %0d y %0d pen %0d",
                     e.visible, e.pixel_x, e.pixel_y, e.pen, out_word.visible,
                     out_word.pixel_x, out_word.pixel_y, out_word.pen);
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t rows [$];
    errors = 0; cycles = 0;
    rst_n = 1'b0; start = 1'b0; in_word = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    sh_width = RST_SCREEN_WIDTH; sh_height = RST_SCREEN_HEIGHT;
    sh_step = RST_DEPTH_STEP; sh_far = RST_FAR_DEPTH; sh_band = RST_PEN_BAND;
    for (int i = 0; i < NSTARS; i++) begin
      star_x[i] = '0; star_y[i] = '0; star_z[i] = '0; star_loaded[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under reset settings
    rows.push_back('{mk(MODE_LOAD, 0, 0, 0, 500), 1, mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(MODE_ADVANCE, 0, 7, 7, 0), 1, mk_res(1, 160, 128, 3)});
    rows.push_back('{mk(MODE_LOAD, 511, 32767, -32768, 1023), 1, mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(MODE_ADVANCE, 511, -1, -1, 1023), 0, '0});
    rows.push_back('{mk(MODE_LOAD, 1, -15000, 24999, 5), 1, mk_res(0, 0, 0, 0)});
    // respawn of a star that passed the viewer
    rows.push_back('{mk(MODE_ADVANCE, 1, 100, -100, 0), 1, mk_res(1, 160, 128, 3)});
    rows.push_back('{mk(MODE_LOAD, 2, 0, 0, 0), 1, mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(MODE_ADVANCE, 2, -32768, 32767, 0), 0, '0});
    // right edge is off screen
    rows.push_back('{mk(MODE_LOAD, 3, 1600, 1280, 20), 1, mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(MODE_ADVANCE, 3, 0, 0, 0), 1, mk_res(0, 0, 0, 0)});
    // negative column is off screen
    rows.push_back('{mk(MODE_LOAD, 4, -1610, 0, 20), 1, mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(MODE_ADVANCE, 4, 0, 0, 0), 1, mk_res(0, 0, 0, 0)});
    // last pixel on screen
    rows.push_back('{mk(MODE_LOAD, 5, 1590, 1270, 20), 1, mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(MODE_ADVANCE, 5, 0, 0, 0), 1, mk_res(1, 319, 255, 1)});
    rows.push_back('{mk(MODE_ADVANCE, 5, 24999, -15000, 0), 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    // random phases, one per register setting
    random_phase(RAND_WORDS);
    drain();
    set_regs(4096, 4096, 255, 1023, 1023);
    random_phase(RAND_WORDS);
    drain();
    set_regs(1, 1, 1, 1, 1);
    random_phase(RAND_WORDS);
    drain();
    set_regs(8191, 8191, 0, 0, 0);
    random_phase(RAND_WORDS);
    drain();
    set_regs(0, 200, 3, 700, 50);
    random_phase(RAND_WORDS / 2);
    drain();
    set_regs(640, 480, 17, 900, 300);
    random_phase(RAND_WORDS);
    drain();

    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/spu_pkg.sv
sv/spu_front.sv
sv/spu_queue.sv
sv/spu_back.sv
sv/starfield_projection_unit.sv
bench/tb_starfield_projection_unit.sv
